/* hw/rtl/itd_pkg.sv */
// ----------------------------------------------------------------------------
// itd_pkg
// Shared types and codes for the interval task dispatcher: command and
// status codes, the table entry layout and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package itd_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 8;

    // command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_ENABLE  = 3'd3;
    localparam logic [2:0] CMD_DISABLE = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // one task table entry
    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] interval;
        logic [31:0] last_time;
        logic        enabled;
        logic [31:0] runs;
    } entry_t;

    // table write data selection
    typedef logic [1:0] wr_sel_t;
    localparam wr_sel_t WR_NEW  = 2'd0;
    localparam wr_sel_t WR_TICK = 2'd1;
    localparam wr_sel_t WR_COPY = 2'd2;
    localparam wr_sel_t WR_FLAG = 2'd3;

    // result emission kinds
    typedef logic [1:0] emit_t;
    localparam emit_t EM_NONE     = 2'd0;
    localparam emit_t EM_STATUS   = 2'd1;
    localparam emit_t EM_QUERY    = 2'd2;
    localparam emit_t EM_TICK_END = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       used_inc;
        logic       used_dec;
        logic       push;
        emit_t      emit;
        logic [1:0] status;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       hit;
        logic       fire;
    } sts_t;

endpackage

/* hw/rtl/interval_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// interval_task_dispatcher
// Ordered table of periodic tasks driven by tick, add, remove, enable,
// disable and query commands; a tick reports every due task in table order.
// ----------------------------------------------------------------------------
// Operation: the table is walked one slot per cycle through a registered-read
//   memory over the entries in use, a search stopping at a match; remove then
//   moves each later entry up one slot.
// Throughput: one item at a time, results cannot be held off by the receiver;
//   busy is low again when the last one-cycle done strobe shows.
// Reset: rst_n clears the entry count and control state, not the table.
module interval_task_dispatcher #(
    parameter int TABLE_DEPTH = itd_pkg::TABLE_DEPTH_DEF,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    cmd,
    input  logic [7:0]    task_id,
    input  logic [31:0]   interval_ms,
    input  logic [31:0]   now_ms,
    output logic          done,
    output logic [1:0]    status,
    output logic          fired,
    output logic [7:0]    fired_task,
    output logic          last_result,
    output logic          query_enabled,
    output logic [31:0]   query_interval,
    output logic [31:0]   query_last_time,
    output logic [31:0]   query_runs,
    output logic [CW-1:0] entries_used
);

    itd_pkg::ctl_t ctl;
    itd_pkg::sts_t sts;
    logic [CW-1:0] used;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // sequencer
    itd_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .sts     (sts),
        .used    (used),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr)
    );

    // table and result datapath
    itd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .cmd             (cmd),
        .task_id         (task_id),
        .interval_ms     (interval_ms),
        .now_ms          (now_ms),
        .sts             (sts),
        .used            (used),
        .done            (done),
        .status          (status),
        .fired           (fired),
        .fired_task      (fired_task),
        .last_result     (last_result),
        .query_enabled   (query_enabled),
        .query_interval  (query_interval),
        .query_last_time (query_last_time),
        .query_runs      (query_runs),
        .entries_used    (entries_used)
    );

endmodule

/* hw/rtl/itd_ctrl.sv */
// ----------------------------------------------------------------------------
// itd_ctrl
// Controller for the interval task dispatcher. Walks the task table one slot
// per cycle for search and tick, then runs the compaction pass on remove.
// ----------------------------------------------------------------------------
module itd_ctrl #(
    parameter int TABLE_DEPTH = itd_pkg::TABLE_DEPTH_DEF,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  itd_pkg::sts_t      sts,
    input  logic [CW-1:0]      used,
    output itd_pkg::ctl_t      ctl,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW:0]   ptr_inc, ptr_inc2, used_ext;
    logic          in_range, full;

    // slot arithmetic
    assign ptr_inc  = {1'b0, ptr_reg} + (CW + 1)'(1);
    assign ptr_inc2 = {1'b0, ptr_reg} + (CW + 1)'(2);
    assign used_ext = {1'b0, used};
    assign in_range = ptr_reg < used;
    assign full     = used == DEPTH_C;
    assign busy     = state_reg != S_IDLE;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        ctl        = '0;
        ctl.status = itd_pkg::ST_OK;
        rd_addr    = '0;
        wr_addr    = ptr_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    ptr_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read slot ahead while this slot is evaluated
                if (ptr_inc < used_ext)
                    rd_addr = ptr_inc[AW-1:0];
                unique case (sts.cmd)
                    itd_pkg::CMD_TICK:
                    begin
                        if (in_range)
                        begin
                            if (sts.fire)
                            begin
                                ctl.wr_en  = 1'b1;
                                ctl.wr_sel = itd_pkg::WR_TICK;
                                ctl.push   = 1'b1;
                            end
                            ptr_next = ptr_inc[CW-1:0];
                        end
                        else
                        begin
                            ctl.emit   = itd_pkg::EM_TICK_END;
                            state_next = S_IDLE;
                        end
                    end
                    itd_pkg::CMD_ADD:
                    begin
                        priority if (full)
                        begin
                            ctl.emit   = itd_pkg::EM_STATUS;
                            ctl.status = itd_pkg::ST_FULL;
                            state_next = S_IDLE;
                        end
                        else if (in_range && sts.hit)
                        begin
                            ctl.emit   = itd_pkg::EM_STATUS;
                            ctl.status = itd_pkg::ST_DUP;
                            state_next = S_IDLE;
                        end
                        else if (in_range)
                        begin
                            ptr_next = ptr_inc[CW-1:0];
                        end
                        else
                        begin
                            ctl.wr_en    = 1'b1;
                            ctl.wr_sel   = itd_pkg::WR_NEW;
                            wr_addr      = used[AW-1:0];
                            ctl.used_inc = 1'b1;
                            ctl.emit     = itd_pkg::EM_STATUS;
                            state_next   = S_IDLE;
                        end
                    end
                    itd_pkg::CMD_REMOVE, itd_pkg::CMD_ENABLE,
                    itd_pkg::CMD_DISABLE, itd_pkg::CMD_QUERY:
                    begin
                        priority if (in_range && sts.hit)
                        begin
                            unique case (sts.cmd)
                                itd_pkg::CMD_ENABLE, itd_pkg::CMD_DISABLE:
                                begin
                                    ctl.wr_en  = 1'b1;
                                    ctl.wr_sel = itd_pkg::WR_FLAG;
                                    ctl.emit   = itd_pkg::EM_STATUS;
                                    state_next = S_IDLE;
                                end
                                itd_pkg::CMD_QUERY:
                                begin
                                    ctl.emit   = itd_pkg::EM_QUERY;
                                    state_next = S_IDLE;
                                end
                                default:
                                begin
                                    // remove: close the gap if later entries exist
                                    if (ptr_inc < used_ext)
                                    begin
                                        state_next = S_SHIFT;
                                    end
                                    else
                                    begin
                                        ctl.used_dec = 1'b1;
                                        ctl.emit     = itd_pkg::EM_STATUS;
                                        state_next   = S_IDLE;
                                    end
                                end
                            endcase
                        end
                        else if (in_range)
                        begin
                            ptr_next = ptr_inc[CW-1:0];
                        end
                        else
                        begin
                            ctl.emit   = itd_pkg::EM_STATUS;
                            ctl.status = itd_pkg::ST_MISSING;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        ctl.emit   = itd_pkg::EM_STATUS;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // read data holds slot ptr+1, moved down to slot ptr
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = itd_pkg::WR_COPY;
                if (ptr_inc2 < used_ext)
                begin
                    rd_addr  = ptr_inc2[AW-1:0];
                    ptr_next = ptr_inc[CW-1:0];
                end
                else
                begin
                    ctl.used_dec = 1'b1;
                    ctl.emit     = itd_pkg::EM_STATUS;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

endmodule

/* hw/rtl/itd_datapath.sv */
// ----------------------------------------------------------------------------
// itd_datapath
// Datapath for the interval task dispatcher: task table memory, command
// registers, fire test, entry count, pending tick result and result registers.
// ----------------------------------------------------------------------------
module itd_datapath #(
    parameter int TABLE_DEPTH = itd_pkg::TABLE_DEPTH_DEF,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  itd_pkg::ctl_t      ctl,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  logic [2:0]         cmd,
    input  logic [7:0]         task_id,
    input  logic [31:0]        interval_ms,
    input  logic [31:0]        now_ms,
    output itd_pkg::sts_t      sts,
    output logic [CW-1:0]      used,
    output logic               done,
    output logic [1:0]         status,
    output logic               fired,
    output logic [7:0]         fired_task,
    output logic               last_result,
    output logic               query_enabled,
    output logic [31:0]        query_interval,
    output logic [31:0]        query_last_time,
    output logic [31:0]        query_runs,
    output logic [CW-1:0]      entries_used
);

    itd_pkg::entry_t mem [TABLE_DEPTH];
    itd_pkg::entry_t rd_data_reg;
    itd_pkg::entry_t wr_data;

    logic [2:0]    cmd_reg;
    logic [7:0]    id_reg;
    logic [31:0]   interval_reg;
    logic [31:0]   now_reg;
    logic [31:0]   elapsed;

    logic [CW-1:0] used_reg, used_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_id_reg, pend_id_next;

    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic          fired_reg, fired_next;
    logic [7:0]    fired_task_reg, fired_task_next;
    logic          last_reg, last_next;
    logic          q_en_reg, q_en_next;
    logic [31:0]   q_int_reg, q_int_next;
    logic [31:0]   q_last_reg, q_last_next;
    logic [31:0]   q_runs_reg, q_runs_next;
    logic [CW-1:0] entries_reg, entries_next;

    // command capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg      <= cmd;
            id_reg       <= task_id;
            interval_reg <= interval_ms;
            now_reg      <= now_ms;
        end
    end

    // match and due test on the slot just read
    assign elapsed  = now_reg - rd_data_reg.last_time;
    assign sts.cmd  = cmd_reg;
    assign sts.hit  = rd_data_reg.id == id_reg;
    assign sts.fire = rd_data_reg.enabled &&
                      ((rd_data_reg.interval == 32'd0) || (elapsed >= rd_data_reg.interval));

    // table write data
    always_comb
    begin
        wr_data = rd_data_reg;
        unique case (ctl.wr_sel)
            itd_pkg::WR_NEW:
            begin
                wr_data.id        = id_reg;
                wr_data.interval  = interval_reg;
                wr_data.last_time = 32'd0;
                wr_data.enabled   = 1'b1;
                wr_data.runs      = 32'd0;
            end
            itd_pkg::WR_TICK:
            begin
                wr_data.last_time = now_reg;
                wr_data.runs      = rd_data_reg.runs + 32'd1;
            end
            itd_pkg::WR_FLAG:
            begin
                wr_data.enabled = cmd_reg == itd_pkg::CMD_ENABLE;
            end
            default:
            begin
                wr_data = rd_data_reg;
            end
        endcase
    end

    // task table, one write when enabled and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // entry count and pending fired id
    always_comb
    begin
        used_next = used_reg;
        if (ctl.used_inc)
            used_next = used_reg + CW'(1);
        else if (ctl.used_dec)
            used_next = used_reg - CW'(1);

        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        if (ctl.load || (ctl.emit == itd_pkg::EM_TICK_END))
            pend_valid_next = 1'b0;
        if (ctl.push)
        begin
            pend_valid_next = 1'b1;
            pend_id_next    = rd_data_reg.id;
        end
    end

    // result formation
    always_comb
    begin
        done_next       = 1'b0;
        status_next     = itd_pkg::ST_OK;
        fired_next      = 1'b0;
        fired_task_next = 8'd0;
        last_next       = 1'b0;
        q_en_next       = 1'b0;
        q_int_next      = 32'd0;
        q_last_next     = 32'd0;
        q_runs_next     = 32'd0;
        entries_next    = used_next;
        if (ctl.push && pend_valid_reg)
        begin
            // an earlier fired task is sent once a later one fires
            done_next       = 1'b1;
            fired_next      = 1'b1;
            fired_task_next = pend_id_reg;
        end
        unique case (ctl.emit)
            itd_pkg::EM_STATUS:
            begin
                done_next   = 1'b1;
                status_next = ctl.status;
                last_next   = 1'b1;
            end
            itd_pkg::EM_QUERY:
            begin
                done_next   = 1'b1;
                last_next   = 1'b1;
                q_en_next   = rd_data_reg.enabled;
                q_int_next  = rd_data_reg.interval;
                q_last_next = rd_data_reg.last_time;
                q_runs_next = rd_data_reg.runs;
            end
            itd_pkg::EM_TICK_END:
            begin
                done_next       = 1'b1;
                last_next       = 1'b1;
                fired_next      = pend_valid_reg;
                fired_task_next = pend_valid_reg ? pend_id_reg : 8'd0;
            end
            default:
            begin
                last_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        status_reg     <= status_next;
        fired_reg      <= fired_next;
        fired_task_reg <= fired_task_next;
        last_reg       <= last_next;
        q_en_reg       <= q_en_next;
        q_int_reg      <= q_int_next;
        q_last_reg     <= q_last_next;
        q_runs_reg     <= q_runs_next;
        entries_reg    <= entries_next;
    end

    assign used            = used_reg;
    assign done            = done_reg;
    assign status          = status_reg;
    assign fired           = fired_reg;
    assign fired_task      = fired_task_reg;
    assign last_result     = last_reg;
    assign query_enabled   = q_en_reg;
    assign query_interval  = q_int_reg;
    assign query_last_time = q_last_reg;
    assign query_runs      = q_runs_reg;
    assign entries_used    = entries_reg;

endmodule

/* hw/rtl/itd_checker.sv */
// ----------------------------------------------------------------------------
// itd_checker
// Port-level checks for the interval task dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module itd_checker #(
    parameter int TABLE_DEPTH = itd_pkg::TABLE_DEPTH_DEF,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input logic [1:0]    status,
    input logic          fired,
    input logic          last_result,
    input logic [CW-1:0] entries_used
);

    // an accepted transfer keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepted transfer");

    // more results still to come means the item is still in progress
    a_partial_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_result |-> busy)
        else $error("non-final result while block idle");

    // only tick results come in groups, and they all report a run
    a_partial_fired: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_result |-> fired)
        else $error("non-final result without fired task");

    // a fired task report always carries ok status
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && fired |-> status == itd_pkg::ST_OK)
        else $error("fired result with error status");

    // table occupancy never exceeds the depth
    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> entries_used <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

endmodule

bind interval_task_dispatcher itd_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_itd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .fired        (fired),
    .last_result  (last_result),
    .entries_used (entries_used)
);
